// ===== sv/asa_pkg.sv =====
package asa_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned ALIGN_W = 4;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned LIVE_W  = 7;
    localparam int unsigned ADJ_W   = 13;
    localparam int unsigned CFG_W   = 32;

    localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 4'd12;

    localparam logic [ADDR_W-1:0] RESET_BASE = 32'd0;
    localparam logic [SIZE_W-1:0] RESET_POOL = 32'd65536;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_SPACE    = 3'd1,
        ST_STACK_FULL  = 3'd2,
        ST_NOTHING     = 3'd3,
        ST_NOT_TOP     = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_BASE_ADDRESS = 1'b0,
        CFG_POOL_BYTES   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ADJ_W-1:0]  adjust;
    } t_header;

endpackage

// ===== sv/asa_if.sv =====
interface asa_req_if;
    import asa_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          opcode;
    logic [SIZE_W-1:0]   request_size;
    logic [ALIGN_W-1:0]  align_log2;
    logic [ADDR_W-1:0]   free_address;

    modport source (output valid, opcode, request_size, align_log2, free_address,
                    input ready);
    modport sink   (input valid, opcode, request_size, align_log2, free_address,
                    output ready);
endinterface

interface asa_rsp_if;
    import asa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   block_address;
    logic [SIZE_W-1:0]   bytes_left;
    logic [LIVE_W-1:0]   live_count;

    modport source (output valid, status, block_address, bytes_left, live_count,
                    input ready);
    modport sink   (input valid, status, block_address, bytes_left, live_count,
                    output ready);
endinterface

// ===== sv/aligned_stack_allocator_top.sv =====
// An accepted item passes through the input register and then the result register before its result is valid.
// One item per cycle while the response side does not stall; state and header stack update in the same pass.
// Top-of-stack header is held in a register, the one below it is prefetched from the
// header RAM, so a free never waits on the RAM read.
// Reset (sync, active low): base 0, pool 65536, stack empty; a config write also empties it.
module aligned_stack_allocator_top #(
    parameter int unsigned MAX_ALLOCATIONS = 64,
    parameter int unsigned HEADER_BYTES    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_idx,
    input  logic [asa_pkg::CFG_W-1:0] i_cfg_data,
    asa_req_if.sink                  i_req,
    asa_rsp_if.source                o_rsp
);
    import asa_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ALLOCATIONS + 1);
    localparam int unsigned AW    = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ALLOCATIONS);
    localparam logic [ADJ_W-1:0] HDR     = ADJ_W'(HEADER_BYTES);

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_pool;

    // allocator state
    logic [ADDR_W-1:0] r_top,   n_top;
    logic [SIZE_W-1:0] r_space, n_space;
    logic [CNT_W-1:0]  r_count, n_count;
    t_header           r_tos, r_nos;
    t_header           mem [MAX_ALLOCATIONS];

    // input register
    logic               r_in_v;
    t_opcode            r_op;
    logic [SIZE_W-1:0]  r_size;
    logic [ALIGN_W-1:0] r_lg;
    logic [ADDR_W-1:0]  r_faddr;

    // result register
    logic              r_out_v;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_block,  n_block;

    logic advance, fire, do_push, do_pop;

    assign advance     = !r_out_v || o_rsp.ready;
    assign fire        = r_in_v && advance;
    assign i_req.ready = !r_in_v || advance;

    // padding computation
    logic [ALIGN_W-1:0] lg;
    logic [ADJ_W-1:0]   mask, adj0, need, adj;

    always_comb begin
        lg   = (r_lg > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : r_lg;
        mask = (ADJ_W'(1) << lg) - ADJ_W'(1);
        adj0 = (ADJ_W'(0) - r_top[ADJ_W-1:0]) & mask;
        need = HDR - adj0;
        adj  = adj0;
        if (adj0 < HDR) begin
            adj = adj0 + (((need + mask) >> lg) << lg);
        end
    end

    logic [ADDR_W-1:0] push_block;
    logic [ADDR_W-1:0] pop_addr;
    logic              no_space;

    assign push_block = r_top + ADDR_W'(adj);
    assign pop_addr   = r_top - r_tos.size;
    assign no_space   = ({1'b0, SIZE_W'(adj)} + {1'b0, r_size}) > {1'b0, r_space};

    always_comb begin
        n_top    = r_top;
        n_space  = r_space;
        n_count  = r_count;
        n_status = ST_OK;
        n_block  = '0;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                priority if (r_count >= CNT_MAX) begin
                    n_status = ST_STACK_FULL;
                end else if (no_space) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    do_push = 1'b1;
                    n_block = push_block;
                    n_top   = push_block + r_size;
                    n_space = r_space - (SIZE_W'(adj) + r_size);
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_FREE: begin
                priority if (r_count == '0) begin
                    n_status = ST_NOTHING;
                end else if (pop_addr != r_faddr) begin
                    n_status = ST_NOT_TOP;
                end else begin
                    do_pop  = 1'b1;
                    n_top   = r_faddr - ADDR_W'(r_tos.adjust);
                    n_space = r_space + r_tos.size + SIZE_W'(r_tos.adjust);
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RESET_BASE;
            r_pool  <= RESET_POOL;
            r_top   <= RESET_BASE;
            r_space <= RESET_POOL;
            r_count <= '0;
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_v <= 1'b1;
            end else if (advance) begin
                r_in_v <= 1'b0;
            end
            if (advance) begin
                r_out_v <= r_in_v;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_ADDRESS: begin
                        r_base <= i_cfg_data;
                        r_top  <= i_cfg_data;
                        r_space <= r_pool;
                    end
                    CFG_POOL_BYTES: begin
                        r_pool  <= i_cfg_data;
                        r_space <= i_cfg_data;
                        r_top   <= r_base;
                    end
                    default: ;
                endcase
                r_count <= '0;
            end else if (fire) begin
                r_top   <= n_top;
                r_space <= n_space;
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_op    <= t_opcode'(i_req.opcode);
            r_size  <= i_req.request_size;
            r_lg    <= i_req.align_log2;
            r_faddr <= i_req.free_address;
        end
        if (fire) begin
            r_status <= n_status;
            r_block  <= n_block;
        end
    end

    // header stack: top in r_tos, next below in r_nos, all entries in mem
    logic [AW-1:0] push_idx, pop_rd_idx;
    logic [CNT_W-1:0] cnt_m3;

    assign cnt_m3     = r_count - CNT_W'(3);
    assign push_idx   = r_count[AW-1:0];
    assign pop_rd_idx = cnt_m3[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (fire && do_push) begin
            mem[push_idx] <= '{size: r_size, adjust: adj};
            r_tos <= '{size: r_size, adjust: adj};
            r_nos <= r_tos;
        end else if (fire && do_pop) begin
            r_tos <= r_nos;
            r_nos <= mem[pop_rd_idx];
        end
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.status        = r_status;
    assign o_rsp.block_address = r_block;
    assign o_rsp.bytes_left    = r_space;
    assign o_rsp.live_count    = LIVE_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("live count above capacity");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && do_push && !i_cfg_we) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("allocate did not advance the count");

    a_pop_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && do_pop && !i_cfg_we) |=> (r_top == $past(r_faddr) - ADDR_W'($past(r_tos.adjust))))
        else $error("free did not restore the top");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_status != ST_OK) |-> (r_block == '0))
        else $error("failed item carries an address");
`endif

endmodule
